// ===== hdl/srtw_pkg.sv =====
// Shared types and codes for the sorted ring table walk unit.
package srtw_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_WALK   = 1'b1;

  localparam logic [2:0] ST_ENTRY    = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_ABSENT   = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  new_key;
    logic [31:0] new_payload;
    logic [7:0]  start_key;
    logic        walk_down;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_key;
    logic [31:0] out_payload;
    logic [2:0]  status;
    logic        last;
  } res_item_t;

  typedef struct packed {
    logic        walk;
    logic        down;
    logic [7:0]  key;
    logic [31:0] payload;
  } cmd_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_INS,
    ENG_FIND,
    ENG_WALK
  } eng_state_t;

endpackage

// ===== hdl/srtw_front.sv =====
// Front end: accepts input beats, masks keys and turns them into commands.
module srtw_front
  import srtw_pkg::*;
#(
  parameter int KEY_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd_data
);

  localparam logic [7:0] KeyMask = (KEY_BITS >= 8) ? 8'hFF : 8'((1 << KEY_BITS) - 1);

  logic valid_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;

  assign in_ready  = !valid_r || cmd_ready;
  assign cmd_valid = valid_r;
  assign cmd_data  = cmd_r;

  always_comb begin
    cmd_nxt.walk    = (in_data.req_type == REQ_WALK);
    cmd_nxt.down    = in_data.walk_down;
    cmd_nxt.payload = in_data.new_payload;
    if (in_data.req_type == REQ_WALK) begin
      cmd_nxt.key = in_data.start_key & KeyMask;
    end else begin
      cmd_nxt.key = in_data.new_key & KeyMask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (cmd_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== hdl/srtw_cmd_fifo.sv =====
// Two-entry command queue between the front end and the table engine.
module srtw_cmd_fifo
  import srtw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/srtw_engine.sv =====
// Table engine: sorted insert by shifting, start-key search and ring walk.
module srtw_engine
  import srtw_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd_data,
  output logic      out_valid,
  input  logic      out_ready,
  output res_item_t out_data
);

  localparam int KW = (KEY_BITS < 8) ? KEY_BITS : 8;
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int W2 = CW + 1;
  localparam int MW = KW + 32;

  logic [MW-1:0] mem [TABLE_DEPTH];
  logic [MW-1:0] rd_q;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wa;
  logic [MW-1:0] wd;

  eng_state_t    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [IW-1:0] nidx_r, nidx_nxt;
  logic [CW-1:0] e_r, e_nxt;
  logic [MW-1:0] cur_r, cur_nxt;
  logic [KW-1:0] op_key_r, op_key_nxt;
  logic [31:0]   op_pay_r, op_pay_nxt;
  logic          op_down_r, op_down_nxt;
  logic          ov_r, ov_nxt;
  res_item_t     od_r, od_nxt;

  logic          can_emit;
  logic          pop;
  logic          full;
  logic [KW-1:0] rd_key;
  logic          key_hit;
  logic          ins_done;
  logic          find_end;
  logic          wlast;
  logic [IW-1:0] step_in;
  logic [IW-1:0] step_out;
  logic [W2-1:0] step_inc;
  logic          emit;
  res_item_t     emit_data;

  assign can_emit  = !ov_r || out_ready;
  assign pop       = (state_r == ENG_IDLE) && cmd_valid && can_emit;
  assign cmd_ready = (state_r == ENG_IDLE) && can_emit;
  assign full      = (count_r == CW'(TABLE_DEPTH));
  assign rd_key    = rd_q[MW-1:32];
  assign key_hit   = (rd_key == op_key_r);
  assign ins_done  = (i_r == '0) || (rd_key < op_key_r);
  assign find_end  = (W2'(j_r) + W2'(1) == W2'(count_r));
  assign wlast     = key_hit || (e_r + CW'(1) == count_r);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  assign step_in  = (state_r == ENG_FIND) ? j_r : nidx_r;
  assign step_inc = W2'(step_in) + W2'(1);

  always_comb begin
    if (op_down_r) begin
      if (step_in == '0) begin
        step_out = IW'(count_r - CW'(1));
      end else begin
        step_out = step_in - IW'(1);
      end
    end else begin
      if (step_inc >= W2'(count_r)) begin
        step_out = '0;
      end else begin
        step_out = IW'(step_inc);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ENG_IDLE: begin
        if (pop) begin
          if (!cmd_data.walk) begin
            if (!full && count_r != '0) begin
              state_nxt = ENG_INS;
            end
          end else if (count_r != '0) begin
            state_nxt = ENG_FIND;
          end
        end
      end
      ENG_INS: begin
        if (ins_done && can_emit) begin
          state_nxt = ENG_IDLE;
        end
      end
      ENG_FIND: begin
        if (key_hit) begin
          state_nxt = ENG_WALK;
        end else if (find_end && can_emit) begin
          state_nxt = ENG_IDLE;
        end
      end
      ENG_WALK: begin
        if (can_emit && wlast) begin
          state_nxt = ENG_IDLE;
        end
      end
      default: state_nxt = ENG_IDLE;
    endcase
  end

  always_comb begin
    count_nxt   = count_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    nidx_nxt    = nidx_r;
    e_nxt       = e_r;
    cur_nxt     = cur_r;
    op_key_nxt  = op_key_r;
    op_pay_nxt  = op_pay_r;
    op_down_nxt = op_down_r;
    rd_addr     = '0;
    we          = 1'b0;
    wa          = '0;
    wd          = {op_key_r, op_pay_r};
    emit        = 1'b0;
    emit_data   = '0;
    emit_data.last = 1'b1;
    case (state_r)
      ENG_IDLE: begin
        if (pop) begin
          op_key_nxt  = cmd_data.key[KW-1:0];
          op_pay_nxt  = cmd_data.payload;
          op_down_nxt = cmd_data.down;
          if (!cmd_data.walk) begin
            if (full) begin
              emit             = 1'b1;
              emit_data.status = ST_FULL;
            end else if (count_r == '0) begin
              we               = 1'b1;
              wd               = {cmd_data.key[KW-1:0], cmd_data.payload};
              count_nxt        = count_r + CW'(1);
              emit             = 1'b1;
              emit_data.status = ST_INSERTED;
            end else begin
              i_nxt   = count_r;
              rd_addr = IW'(count_r - CW'(1));
            end
          end else if (count_r == '0) begin
            emit             = 1'b1;
            emit_data.status = ST_EMPTY;
          end else begin
            j_nxt = '0;
          end
        end
      end
      ENG_INS: begin
        rd_addr = (i_r != '0) ? IW'(i_r - CW'(1)) : '0;
        if (ins_done) begin
          if (can_emit) begin
            we               = 1'b1;
            wa               = IW'(i_r);
            count_nxt        = count_r + CW'(1);
            emit             = 1'b1;
            emit_data.status = ST_INSERTED;
          end
        end else begin
          we      = 1'b1;
          wa      = IW'(i_r);
          wd      = rd_q;
          i_nxt   = i_r - CW'(1);
          rd_addr = (i_r >= CW'(2)) ? IW'(i_r - CW'(2)) : '0;
        end
      end
      ENG_FIND: begin
        rd_addr = j_r;
        if (key_hit) begin
          e_nxt    = '0;
          cur_nxt  = rd_q;
          nidx_nxt = step_out;
          rd_addr  = step_out;
        end else if (find_end) begin
          if (can_emit) begin
            emit             = 1'b1;
            emit_data.status = ST_ABSENT;
          end
        end else begin
          j_nxt   = j_r + IW'(1);
          rd_addr = j_r + IW'(1);
        end
      end
      ENG_WALK: begin
        rd_addr = nidx_r;
        if (can_emit) begin
          emit                  = 1'b1;
          emit_data.out_key     = 8'(cur_r[MW-1:32]);
          emit_data.out_payload = cur_r[31:0];
          emit_data.status      = ST_ENTRY;
          emit_data.last        = wlast;
          if (!wlast) begin
            cur_nxt  = rd_q;
            nidx_nxt = step_out;
            e_nxt    = e_r + CW'(1);
            rd_addr  = step_out;
          end
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    if (emit) begin
      ov_nxt = 1'b1;
      od_nxt = emit_data;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENG_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    nidx_r    <= nidx_nxt;
    e_r       <= e_nxt;
    cur_r     <= cur_nxt;
    op_key_r  <= op_key_nxt;
    op_pay_r  <= op_pay_nxt;
    op_down_r <= op_down_nxt;
    od_r      <= od_nxt;
  end

endmodule

// ===== hdl/sorted_ring_table_walk_unit.sv =====
// Top level of the sorted ring table walk unit.
// Path: an accepted beat is registered in the front end and then in the command queue before it reaches the engine.
// Insert: one shift per cycle in the table memory, which is read and written in the same cycle.
// Walk: a linear start-key search from the lowest entry, then one result beat per cycle unless the output stalls.
// The engine handles one item at a time and takes no new command until it is back in idle.
// Reset: synchronous active low; empties the table and queues, table contents stay as they were.
module sorted_ring_table_walk_unit
  import srtw_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output res_item_t out_data
);

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_data;
  logic q_valid;
  logic q_ready;
  cmd_t q_data;

  srtw_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd_data  (fr_data)
  );

  srtw_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  srtw_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  a_mid_is_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == ST_ENTRY)
    else $error("non-final beat carries a status code");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_ENTRY |->
      out_data.out_key == 8'd0 && out_data.out_payload == 32'd0 && out_data.last)
    else $error("status beat carries entry data");

endmodule
